// ===== hw/rtl/ond_pkg.sv =====
// Shared constants and types for the octahedral normal decoder.
// No dependencies; every other file in the block imports this package.
package ond_pkg;

  localparam int CODE_BITS            = 8;
  localparam int NORMAL_FRACTION_BITS = 14;
  localparam int OUT_BITS             = 16;

  localparam int CODE_MAX   = (1 << CODE_BITS) - 1;
  localparam int SCOMP_BITS = CODE_BITS + 2;
  localparam int SQ_BITS    = 2 * CODE_BITS;
  localparam int SUM_BITS   = 2 * CODE_BITS + 2;

  localparam int LANES      = 3;
  localparam int LANE_X     = 0;
  localparam int LANE_Y     = 1;
  localparam int LANE_Z     = 2;

  // One result bit is settled per step, from weight 2^F down to 2^0.
  localparam int NSTEP      = NORMAL_FRACTION_BITS + 1;
  localparam int Q_BITS     = NORMAL_FRACTION_BITS + 1;
  localparam int R_BITS     = 2 * CODE_BITS + 2 * NORMAL_FRACTION_BITS + 2;
  localparam int V_BITS     = 2 * CODE_BITS + 2 * NORMAL_FRACTION_BITS + 6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Classified vector handed from the front end to the normalising pipeline.
  typedef struct packed {
    logic [LANES-1:0][SQ_BITS-1:0] sq;
    logic [LANES-1:0]              neg;
    logic [SUM_BITS-1:0]           sum_sq;
  } ond_vec_t;

endpackage

// ===== hw/rtl/ond_in_if.sv =====
// Input channel: one oct-encoded normal per word.
// Depends on ond_pkg.
interface ond_in_if;
  import ond_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] code_x;
  logic [CODE_BITS-1:0] code_y;

  modport source (output valid, output code_x, output code_y, input ready);
  modport sink   (input valid, input code_x, input code_y, output ready);
endinterface

// ===== hw/rtl/ond_out_if.sv =====
// Output channel: one unit normal in signed fixed point per word.
// Depends on ond_pkg.
interface ond_out_if;
  import ond_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] normal_x;
  logic signed [OUT_BITS-1:0] normal_y;
  logic signed [OUT_BITS-1:0] normal_z;

  modport source (output valid, output normal_x, output normal_y, output normal_z,
                  input ready);
  modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                  output ready);
endinterface

// ===== hw/rtl/ond_front.sv =====
// Front end: takes code pairs, unfolds the octahedron and squares the components.
// Depends on ond_pkg and ond_in_if.
module ond_front (
  input  logic            clk,
  input  logic            rst,
  ond_in_if.sink          codes,
  input  logic            full,
  output logic            push,
  output ond_pkg::ond_vec_t vec
);
  import ond_pkg::*;

  logic                        front_valid;
  ond_vec_t                    vec_next;
  logic signed [SCOMP_BITS-1:0] a, b, zs;
  logic [CODE_BITS-1:0]        aa, ab, mx, my, mz;
  logic                        fold;
  logic [SQ_BITS-1:0]          sqx, sqy, sqz;

  assign push        = front_valid && !full;
  assign codes.ready = !front_valid || !full;

  always_comb begin
    a    = $signed({1'b0, codes.code_x, 1'b0}) - $signed(SCOMP_BITS'(CODE_MAX));
    b    = $signed({1'b0, codes.code_y, 1'b0}) - $signed(SCOMP_BITS'(CODE_MAX));
    aa   = a[SCOMP_BITS-1] ? CODE_BITS'(-a) : a[CODE_BITS-1:0];
    ab   = b[SCOMP_BITS-1] ? CODE_BITS'(-b) : b[CODE_BITS-1:0];
    zs   = $signed(SCOMP_BITS'(CODE_MAX)) - $signed({2'b00, aa}) - $signed({2'b00, ab});
    fold = zs[SCOMP_BITS-1];
    // lower hemisphere: swap in the complement of the other magnitude
    mx   = fold ? CODE_BITS'(CODE_MAX) - ab : aa;
    my   = fold ? CODE_BITS'(CODE_MAX) - aa : ab;
    mz   = fold ? CODE_BITS'(-zs) : zs[CODE_BITS-1:0];
    sqx  = SQ_BITS'(mx) * SQ_BITS'(mx);
    sqy  = SQ_BITS'(my) * SQ_BITS'(my);
    sqz  = SQ_BITS'(mz) * SQ_BITS'(mz);
    vec_next.sq[LANE_X]  = sqx;
    vec_next.sq[LANE_Y]  = sqy;
    vec_next.sq[LANE_Z]  = sqz;
    vec_next.neg[LANE_X] = a[SCOMP_BITS-1];
    vec_next.neg[LANE_Y] = b[SCOMP_BITS-1];
    vec_next.neg[LANE_Z] = fold;
    vec_next.sum_sq      = SUM_BITS'(sqx) + SUM_BITS'(sqy) + SUM_BITS'(sqz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (codes.valid && codes.ready) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (codes.valid && codes.ready) begin
      vec <= vec_next;
    end
  end

endmodule

// ===== hw/rtl/ond_queue.sv =====
// Short queue between the front end and the normalising pipeline.
// Depends on ond_pkg.
module ond_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ond_pkg::ond_vec_t push_data,
  output logic              full,
  input  logic              pop,
  output ond_pkg::ond_vec_t head,
  output logic              head_valid
);
  import ond_pkg::*;

  ond_vec_t               mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0]   count;

  assign full       = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue holds more words than its depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + QCNT_BITS'(1))
    else $error("queue count lost a push");

endmodule

// ===== hw/rtl/ond_back.sv =====
// Normalising pipeline: one result bit per stage for all three components.
// Depends on ond_pkg and ond_out_if.
module ond_back (
  input  logic              clk,
  input  logic              rst,
  input  ond_pkg::ond_vec_t head,
  input  logic              head_valid,
  output logic              pop,
  ond_out_if.source         normals
);
  import ond_pkg::*;

  typedef struct packed {
    logic [Q_BITS-1:0] q;
    logic [V_BITS-1:0] v;   // (2q-1)^2 * S
    logic [V_BITS-1:0] u;   // (2q-1) * S, two's complement
    logic [R_BITS-1:0] r;   // 4 * X^2 * 2^(2F)
    logic              neg;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0]   lane;
    logic [SUM_BITS-1:0] s;
  } stage_t;

  stage_t                   st_in  [NSTEP];
  stage_t                   st_out [NSTEP];
  stage_t                   pipe   [NSTEP-1];
  logic [NSTEP-2:0]         pipe_valid;
  logic                     adv;
  logic                     out_valid;
  logic [LANES-1:0][OUT_BITS-1:0] fmt;
  logic [LANES-1:0][OUT_BITS-1:0] out_data;

  assign adv = !out_valid || normals.ready;
  assign pop = adv && head_valid;

  always_comb begin
    st_in[0].s = head.sum_sq;
    for (int l = 0; l < LANES; l++) begin
      st_in[0].lane[l].q   = '0;
      st_in[0].lane[l].v   = V_BITS'(head.sum_sq);
      st_in[0].lane[l].u   = V_BITS'(0) - V_BITS'(head.sum_sq);
      st_in[0].lane[l].r   = R_BITS'(head.sq[l]) << (2 * NORMAL_FRACTION_BITS + 2);
      st_in[0].lane[l].neg = head.neg[l];
    end
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam int K = NORMAL_FRACTION_BITS - j;

    if (j > 0) begin : g_link
      assign st_in[j] = pipe[j-1];
    end

    always_comb begin
      logic [V_BITS-1:0] t;
      logic [V_BITS-1:0] s_ext;
      logic              ok;
      st_out[j] = st_in[j];
      s_ext     = V_BITS'(st_in[j].s);
      for (int l = 0; l < LANES; l++) begin
        // trial with bit K set: (m + 2^(K+1))^2 S = V + U*2^(K+2) + S*2^(2K+2)
        t  = st_in[j].lane[l].v + (st_in[j].lane[l].u << (K + 2)) + (s_ext << (2 * K + 2));
        ok = (t <= V_BITS'(st_in[j].lane[l].r));
        if (ok) begin
          st_out[j].lane[l].q = st_in[j].lane[l].q | (Q_BITS'(1) << K);
          st_out[j].lane[l].v = t;
          st_out[j].lane[l].u = st_in[j].lane[l].u + (s_ext << (K + 1));
        end
      end
    end
  end

  // sign and fit to the output width; a zero-length vector yields zero
  always_comb begin
    logic [OUT_BITS-1:0] mag;
    for (int l = 0; l < LANES; l++) begin
      mag = OUT_BITS'(st_out[NSTEP-1].lane[l].q);
      if (st_out[NSTEP-1].s == '0) begin
        fmt[l] = '0;
      end else if (st_out[NSTEP-1].lane[l].neg) begin
        fmt[l] = OUT_BITS'(0) - mag;
      end else begin
        fmt[l] = mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      pipe_valid <= {pipe_valid[NSTEP-3:0], head_valid};
      out_valid  <= pipe_valid[NSTEP-2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NSTEP - 1; j++) begin
        pipe[j] <= st_out[j];
      end
      out_data <= fmt;
    end
  end

  assign normals.valid    = out_valid;
  assign normals.normal_x = out_data[LANE_X];
  assign normals.normal_y = out_data[LANE_Y];
  assign normals.normal_z = out_data[LANE_Z];

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !normals.ready) |=> $stable(pipe_valid))
    else $error("pipeline moved while the output word was held");

  a_nonzero_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data[LANE_X] != '0 || out_data[LANE_Y] != '0 ||
                   out_data[LANE_Z] != '0))
    else $error("decoded normal has zero length");

  a_rise_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pipe_valid[NSTEP-2]))
    else $error("output word appeared without a pipeline word behind it");

endmodule

// ===== hw/rtl/oct_normal_decoder_top.sv =====
// Top level of the octahedral normal decoder.
// Depends on ond_pkg, ond_in_if, ond_out_if, ond_front, ond_queue and ond_back.

// Decodes one oct-encoded normal (two unsigned 8-bit codes) per word into a unit
// vector with signed Q1.14 components, rounded to nearest and bounded by +/-1.0.
// The block sustains one word per clock in both directions while the output is
// not stalled. An accepted word passes the front register, then the queue, where
// the first result bit is settled, then one pipeline stage for each remaining
// result bit, the last feeding the output register. The normalising pipeline
// settles one result bit per stage. The block holds no state between words and
// needs no setup after reset.
module oct_normal_decoder_top (
  input  logic       clk,
  input  logic       rst,
  ond_in_if.sink     codes,
  ond_out_if.source  normals
);
  import ond_pkg::*;

  // front end -> queue
  ond_vec_t vec;
  logic     push;
  logic     full;

  // queue -> pipeline
  ond_vec_t head;
  logic     head_valid;
  logic     pop;

  // Unfold the octahedron and square the components; hold the word until the
  // queue has room.
  ond_front u_front (
    .clk   (clk),
    .rst   (rst),
    .codes (codes),
    .full  (full),
    .push  (push),
    .vec   (vec)
  );

  // Decouple the front end from the pipeline so each side can stall alone.
  ond_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (vec),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // Normalise: each stage decides one bit of every component, then drive the
  // registered output word.
  ond_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .normals    (normals)
  );

endmodule
